// File: hdl/sfstb_pkg.sv
// Package for the scaled fixed-step time base: widths, register indexes,
// sequencer and arithmetic unit types. No dependencies.
package sfstb_pkg;

   localparam int TIME_BITS    = 52;
   localparam int MAX_STEP_CAP = 255;

   localparam int OUT_W    = 52;
   localparam int DELTA_W  = 48;
   localparam int GAIN_W   = 17;
   localparam int RATE_W   = 24;
   localparam int STEP_W   = 32;
   localparam int CAP_W    = 8;
   localparam int OFFSET_W = 53;
   localparam int BACKLOG_W = 53;
   localparam int ADJUST_W = 54;
   localparam int ALPHA_W  = 16;
   localparam int FRAC_W   = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 53;

   localparam int A_W   = 53;
   localparam int B_W   = 24;
   localparam int P_W   = A_W + B_W;
   localparam int DIV_W = A_W + FRAC_W;
   localparam int CNT_W = 7;
   localparam int MUL_STEPS = B_W;
   localparam int DIV_STEPS = DIV_W;
   localparam int REM_STEP  = A_W;

   localparam logic [OUT_W-1:0]     OUT_MAX     = {OUT_W{1'b1}};
   localparam logic [BACKLOG_W-1:0] BACKLOG_MAX = {BACKLOG_W{1'b1}};
   localparam logic [GAIN_W-1:0]    GAIN_ONE    = GAIN_W'(1 << FRAC_W);

   localparam logic [CSR_IDX_W-1:0] CSR_RATE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 3'd4;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_MUL      = 12'b0000_0000_0010,
      ST_SCALE    = 12'b0000_0000_0100,
      ST_FIXED    = 12'b0000_0000_1000,
      ST_DIV      = 12'b0000_0001_0000,
      ST_STEPS    = 12'b0000_0010_0000,
      ST_CONSUME  = 12'b0000_0100_0000,
      ST_ADD_TIME = 12'b0000_1000_0000,
      ST_REPORT   = 12'b0001_0000_0000,
      ST_SYNC_ERR = 12'b0010_0000_0000,
      ST_SYNC_ADD = 12'b0100_0000_0000,
      ST_DONE     = 12'b1000_0000_0000
   } state_type;

endpackage

// File: hdl/sfstb_req_if.sv
// Request channel of the scaled fixed-step time base: valid, ready, payload.
// Depends on sfstb_pkg.
interface sfstb_req_if;
   import sfstb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      command;
   logic signed [DELTA_W-1:0] host_delta_ns;
   logic [OUT_W-1:0]          device_now_ns;
   logic [GAIN_W-1:0]         drift_gain_q16;

   modport source (output valid, command, host_delta_ns, device_now_ns, drift_gain_q16,
                   input ready);
   modport sink   (input valid, command, host_delta_ns, device_now_ns, drift_gain_q16,
                   output ready);
endinterface

// File: hdl/sfstb_rsp_if.sv
// Response channel of the scaled fixed-step time base: valid, ready, payload.
// Depends on sfstb_pkg.
interface sfstb_rsp_if;
   import sfstb_pkg::*;

   logic               valid;
   logic               ready;
   logic [OUT_W-1:0]   reported_time_ns;
   logic [OUT_W-1:0]   consumed_delta_ns;
   logic [CAP_W-1:0]   step_count;
   logic [ALPHA_W-1:0] alpha_q16;

   modport source (output valid, reported_time_ns, consumed_delta_ns, step_count, alpha_q16,
                   input ready);
   modport sink   (input valid, reported_time_ns, consumed_delta_ns, step_count, alpha_q16,
                   output ready);
endinterface

// File: hdl/sfstb_iter_unit.sv
// Shared iterative unit: shift-add multiply and restoring divide on one adder.
// Depends on sfstb_pkg.
module sfstb_iter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  sfstb_pkg::unit_ctrl_type        ctrl,
   input  logic [sfstb_pkg::A_W-1:0]       opa,
   input  logic [sfstb_pkg::STEP_W-1:0]    opb,
   output sfstb_pkg::unit_stat_type        stat,
   output logic [sfstb_pkg::P_W-1:0]       result,
   output logic [sfstb_pkg::STEP_W-1:0]    rem_mid
);
   import sfstb_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   op_type            op_ff, op_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [P_W-1:0]    acc_ff, acc_in;
   logic [A_W-1:0]    a_ff, a_in;
   logic [STEP_W-1:0] b_ff, b_in;
   logic [STEP_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] rem_mid_ff, rem_mid_in;

   logic [STEP_W:0]   shifted;
   logic [P_W-1:0]    add_x, add_y, add_sum;
   logic              add_cin;
   logic              ge;
   logic [CNT_W-1:0]  last;

   always_comb begin
      shifted = {rem_ff, acc_ff[DIV_W-1]};
      if (op_ff == OP_MUL) begin
         add_x   = {acc_ff[P_W-2:0], 1'b0};
         add_y   = b_ff[B_W-1] ? P_W'(a_ff) : '0;
         add_cin = 1'b0;
      end else begin
         add_x   = P_W'(shifted);
         add_y   = ~P_W'(b_ff);
         add_cin = 1'b1;
      end
      add_sum = add_x + add_y + P_W'(add_cin);
      ge      = ~add_sum[P_W-1];
      last    = (op_ff == OP_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(DIV_STEPS - 1);

      busy_in    = busy_ff;
      done_in    = 1'b0;
      op_in      = op_ff;
      count_in   = count_ff;
      acc_in     = acc_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      rem_in     = rem_ff;
      rem_mid_in = rem_mid_ff;

      if (ctrl.start) begin
         busy_in  = 1'b1;
         op_in    = ctrl.op;
         count_in = '0;
         a_in     = opa;
         b_in     = opb;
         rem_in   = '0;
         acc_in   = (ctrl.op == OP_MUL) ? '0 : P_W'({opa, {FRAC_W{1'b0}}});
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            acc_in = add_sum;
            b_in   = {b_ff[STEP_W-2:0], 1'b0};
         end else begin
            acc_in = {acc_ff[P_W-2:0], ge};
            rem_in = ge ? add_sum[STEP_W-1:0] : shifted[STEP_W-1:0];
            if (count_ff == CNT_W'(REM_STEP - 1)) begin
               rem_mid_in = rem_in;
            end
         end
         count_in = count_ff + 1'b1;
         if (count_ff == last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff      <= op_in;
      count_ff   <= count_in;
      acc_ff     <= acc_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      rem_ff     <= rem_in;
      rem_mid_ff <= rem_mid_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = acc_ff;
   assign rem_mid   = rem_mid_ff;

endmodule

// File: hdl/scaled_fixed_step_time_base.sv
// Top level of the scaled fixed-step time base: registers, sequencer, time state.
// Depends on sfstb_pkg, sfstb_req_if, sfstb_rsp_if and sfstb_iter_unit.
//
// One transaction at a time. A sync gives no response. An advance in variable mode
// runs a 24-step shift-add multiply for the rate; in fixed-step mode it runs the
// same multiply, then a 69-step restoring divide of the backlog by the step that
// yields the step count and alpha. Both iterate on the one shared adder.
// Request ready is high only while the sequencer is idle; a finished response
// waits in the output register while the next request is taken.
module scaled_fixed_step_time_base (
   input  logic                                 clock,
   input  logic                                 reset,
   sfstb_req_if.sink                            req_bus,
   sfstb_rsp_if.source                          rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [sfstb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sfstb_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import sfstb_pkg::*;

   localparam int RPT_W = ((TIME_BITS > OFFSET_W + 2) ? TIME_BITS : OFFSET_W + 2) + 2;
   localparam int NA_W  = ADJUST_W + 2;
   localparam logic signed [NA_W-1:0] ADJ_MAX = NA_W'((64'd1 << (ADJUST_W - 1)) - 64'd1);
   localparam logic signed [NA_W-1:0] ADJ_MIN = -ADJ_MAX - NA_W'(1);

   state_type state_ff, state_in;

   logic [RATE_W-1:0]          rate_ff, rate_in;
   logic                       pause_ff, pause_in;
   logic [STEP_W-1:0]          step_ns_ff, step_ns_in;
   logic [CAP_W-1:0]           cap_ff, cap_in;
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;

   logic [TIME_BITS-1:0]       time_ff, time_in;
   logic [BACKLOG_W-1:0]       backlog_ff, backlog_in;
   logic signed [ADJUST_W-1:0] adjust_ff, adjust_in;
   logic [ALPHA_W-1:0]         alpha_ff, alpha_in;

   logic                       cmd_ff, cmd_in;
   logic [OUT_W-1:0]           dev_ff, dev_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic                       neg_ff, neg_in;
   logic [OUT_W-1:0]           report_ff, report_in;
   logic [OUT_W-1:0]           scaled_ff, scaled_in;
   logic [OUT_W-1:0]           consumed_ff, consumed_in;
   logic [CAP_W-1:0]           steps_ff, steps_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]           rsp_time_ff, rsp_time_in;
   logic [OUT_W-1:0]           rsp_consumed_ff, rsp_consumed_in;
   logic [CAP_W-1:0]           rsp_steps_ff, rsp_steps_in;
   logic [ALPHA_W-1:0]         rsp_alpha_ff, rsp_alpha_in;

   unit_ctrl_type              unit_ctrl;
   unit_stat_type              unit_stat;
   logic [A_W-1:0]             unit_opa;
   logic [STEP_W-1:0]          unit_opb;
   logic [P_W-1:0]             unit_result;
   logic [STEP_W-1:0]          unit_rem;

   logic                       req_take;
   logic                       no_work;
   logic [CAP_W-1:0]           cap_eff;
   logic signed [RPT_W-1:0]    rpt_time, rpt_adj, rpt_sum;
   logic [OUT_W-1:0]           report_val;
   logic [P_W-FRAC_W-1:0]      prod_hi;
   logic [OUT_W-1:0]           scaled_val;
   logic [BACKLOG_W:0]         backlog_sum;
   logic [A_W-1:0]             quot;
   logic [CAP_W+STEP_W-1:0]    consumed_prod;
   logic signed [OUT_W:0]      err;
   logic [A_W-1:0]             err_mag;
   logic [GAIN_W-1:0]          gain_sat;
   logic signed [NA_W-1:0]     corr_ext, na;

   sfstb_iter_unit u_iter (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (unit_ctrl),
      .opa     (unit_opa),
      .opb     (unit_opb),
      .stat    (unit_stat),
      .result  (unit_result),
      .rem_mid (unit_rem)
   );

   always_comb begin
      cap_eff = (cap_ff == '0) ? CAP_W'(1) :
                ((32'(cap_ff) > MAX_STEP_CAP) ? CAP_W'(MAX_STEP_CAP) : cap_ff);

      rpt_time = RPT_W'(time_ff);
      rpt_adj  = RPT_W'(offset_ff) + RPT_W'(adjust_ff);
      rpt_sum  = rpt_time + rpt_adj;
      if (rpt_sum[RPT_W-1]) begin
         report_val = '0;
      end else if (rpt_sum > RPT_W'(OUT_MAX)) begin
         report_val = OUT_MAX;
      end else begin
         report_val = rpt_sum[OUT_W-1:0];
      end

      prod_hi    = unit_result[P_W-1:FRAC_W];
      scaled_val = (|prod_hi[P_W-FRAC_W-1:OUT_W]) ? OUT_MAX : prod_hi[OUT_W-1:0];

      backlog_sum   = (BACKLOG_W + 1)'(backlog_ff) + (BACKLOG_W + 1)'(scaled_ff);
      quot          = unit_result[DIV_W-1:FRAC_W];
      consumed_prod = steps_ff * step_ns_ff;

      err      = $signed({1'b0, dev_ff}) - $signed({1'b0, report_ff});
      err_mag  = err[OUT_W] ? A_W'(-err) : A_W'(err);
      gain_sat = (gain_ff > GAIN_ONE) ? GAIN_ONE : gain_ff;
      corr_ext = NA_W'(unit_result[FRAC_W+A_W-1:FRAC_W]);
      na       = neg_ff ? (NA_W'(adjust_ff) - corr_ext) : (NA_W'(adjust_ff) + corr_ext);

      req_take = req_bus.valid && (state_ff == ST_IDLE);
      no_work  = pause_ff || req_bus.host_delta_ns[DELTA_W-1] ||
                 (req_bus.host_delta_ns == '0) || (rate_ff == '0);

      state_in    = state_ff;
      rate_in     = rate_ff;
      pause_in    = pause_ff;
      step_ns_in  = step_ns_ff;
      cap_in      = cap_ff;
      offset_in   = offset_ff;
      time_in     = time_ff;
      backlog_in  = backlog_ff;
      adjust_in   = adjust_ff;
      alpha_in    = alpha_ff;
      cmd_in      = cmd_ff;
      dev_in      = dev_ff;
      gain_in     = gain_ff;
      neg_in      = neg_ff;
      report_in   = report_ff;
      scaled_in   = scaled_ff;
      consumed_in = consumed_ff;
      steps_in    = steps_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_time_in     = rsp_time_ff;
      rsp_consumed_in = rsp_consumed_ff;
      rsp_steps_in    = rsp_steps_ff;
      rsp_alpha_in    = rsp_alpha_ff;

      unit_ctrl.start = 1'b0;
      unit_ctrl.op    = OP_MUL;
      unit_opa        = A_W'(req_bus.host_delta_ns[DELTA_W-2:0]);
      unit_opb        = STEP_W'(rate_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in      = req_bus.command;
               dev_in      = req_bus.device_now_ns;
               gain_in     = req_bus.drift_gain_q16;
               consumed_in = '0;
               steps_in    = '0;
               if (req_bus.command || no_work) begin
                  state_in = ST_REPORT;
               end else begin
                  unit_ctrl.start = 1'b1;
                  state_in        = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (unit_stat.done) begin
               state_in = cmd_ff ? ST_SYNC_ADD : ST_SCALE;
            end
         end
         ST_SCALE: begin
            scaled_in = scaled_val;
            if (scaled_val == '0) begin
               state_in = ST_REPORT;
            end else if (step_ns_ff == '0) begin
               time_in     = time_ff + TIME_BITS'(scaled_val);
               consumed_in = scaled_val;
               steps_in    = CAP_W'(1);
               state_in    = ST_REPORT;
            end else begin
               state_in = ST_FIXED;
            end
         end
         ST_FIXED: begin
            backlog_in      = backlog_sum[BACKLOG_W] ? BACKLOG_MAX
                                                     : backlog_sum[BACKLOG_W-1:0];
            unit_ctrl.start = 1'b1;
            unit_ctrl.op    = OP_DIV;
            unit_opa        = backlog_in;
            unit_opb        = step_ns_ff;
            state_in        = ST_DIV;
         end
         ST_DIV: begin
            if (unit_stat.done) begin
               state_in = ST_STEPS;
            end
         end
         ST_STEPS: begin
            steps_in   = (quot < A_W'(cap_eff)) ? quot[CAP_W-1:0] : cap_eff;
            backlog_in = BACKLOG_W'(unit_rem);
            alpha_in   = unit_result[FRAC_W-1:0];
            state_in   = ST_CONSUME;
         end
         ST_CONSUME: begin
            consumed_in = OUT_W'(consumed_prod);
            state_in    = ST_ADD_TIME;
         end
         ST_ADD_TIME: begin
            time_in  = time_ff + TIME_BITS'(consumed_ff);
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            report_in = report_val;
            state_in  = cmd_ff ? ST_SYNC_ERR : ST_DONE;
         end
         ST_SYNC_ERR: begin
            neg_in          = err[OUT_W];
            unit_ctrl.start = 1'b1;
            unit_opa        = err_mag;
            unit_opb        = STEP_W'(gain_sat);
            state_in        = ST_MUL;
         end
         ST_SYNC_ADD: begin
            if (na > ADJ_MAX) begin
               adjust_in = ADJUST_W'(ADJ_MAX);
            end else if (na < ADJ_MIN) begin
               adjust_in = ADJUST_W'(ADJ_MIN);
            end else begin
               adjust_in = ADJUST_W'(na);
            end
            state_in = ST_IDLE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_time_in     = report_ff;
               rsp_consumed_in = consumed_ff;
               rsp_steps_in    = steps_ff;
               rsp_alpha_in    = alpha_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         case (csr_index)
            CSR_RATE:   rate_in  = csr_write_data[RATE_W-1:0];
            CSR_PAUSE:  pause_in = csr_write_data[0];
            CSR_STEP: begin
               step_ns_in = csr_write_data[STEP_W-1:0];
               backlog_in = '0;
               alpha_in   = '0;
            end
            CSR_CAP: begin
               cap_in     = csr_write_data[CAP_W-1:0];
               backlog_in = '0;
               alpha_in   = '0;
            end
            CSR_OFFSET: begin
               offset_in = $signed(csr_write_data[OFFSET_W-1:0]);
               adjust_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= RATE_W'(1 << FRAC_W);
         pause_ff     <= 1'b0;
         step_ns_ff   <= '0;
         cap_ff       <= CAP_W'(1);
         offset_ff    <= '0;
         time_ff      <= '0;
         backlog_ff   <= '0;
         adjust_ff    <= '0;
         alpha_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff      <= rate_in;
         pause_ff     <= pause_in;
         step_ns_ff   <= step_ns_in;
         cap_ff       <= cap_in;
         offset_ff    <= offset_in;
         time_ff      <= time_in;
         backlog_ff   <= backlog_in;
         adjust_ff    <= adjust_in;
         alpha_ff     <= alpha_in;
      end
      cmd_ff          <= cmd_in;
      dev_ff          <= dev_in;
      gain_ff         <= gain_in;
      neg_ff          <= neg_in;
      report_ff       <= report_in;
      scaled_ff       <= scaled_in;
      consumed_ff     <= consumed_in;
      steps_ff        <= steps_in;
      rsp_time_ff     <= rsp_time_in;
      rsp_consumed_ff <= rsp_consumed_in;
      rsp_steps_ff    <= rsp_steps_in;
      rsp_alpha_ff    <= rsp_alpha_in;
   end

   assign req_bus.ready             = (state_ff == ST_IDLE);
   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.reported_time_ns  = rsp_time_ff;
   assign rsp_bus.consumed_delta_ns = rsp_consumed_ff;
   assign rsp_bus.step_count        = rsp_steps_ff;
   assign rsp_bus.alpha_q16         = rsp_alpha_ff;

   a_done_in_iter: assert property (@(posedge clock) disable iff (reset)
      unit_stat.done |-> (state_ff == ST_MUL || state_ff == ST_DIV))
      else $error("arithmetic unit finished outside an iterate state");

   a_backlog_below_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONSUME && !$past(csr_write_enable)) |->
         (backlog_ff < BACKLOG_W'(step_ns_ff)))
      else $error("backlog holds a whole step after the divide");

   a_sync_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SYNC_ADD) |=> !$rose(rsp_valid_ff))
      else $error("sync transaction produced a response");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_bus.ready)) |=>
         (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished advance not loaded into the output register");

endmodule
